### rtl/core/gpc_pkg.sv
`default_nettype none

package gpc_pkg;

    // row buffer depth, the widest grid that can be configured
    localparam int MAX_WIDTH     = 128;
    localparam int COL_W         = $clog2(MAX_WIDTH);

    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_W         = $clog2(HEIGHT_LIMIT);

    localparam int COUNT_W       = 30;
    localparam int GRID_WIDTH_W  = 8;
    localparam int GRID_HEIGHT_W = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [COUNT_W-1:0] PRIME = COUNT_W'(1000000007);

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT
    } cfg_index_t;

    // per-cell control from the grid counter
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/gpc_in_if.sv
`default_nettype none

interface gpc_in_if;
    logic valid;
    logic ready;
    logic blocked;

    modport source (output valid, output blocked, input ready);
    modport sink   (input valid, input blocked, output ready);
endinterface

`default_nettype wire

### rtl/core/gpc_out_if.sv
`default_nettype none

interface gpc_out_if
    import gpc_pkg::*;
;
    logic   valid;
    logic   ready;
    count_t path_count;
    logic   is_final;

    modport source (output valid, output path_count, output is_final, input ready);
    modport sink   (input valid, input path_count, input is_final, output ready);
endinterface

`default_nettype wire

### rtl/core/gpc_cell.sv
`default_nettype none

module gpc_cell
    import gpc_pkg::*;
(
    input  wire        clk,
    input  cell_ctrl_t ctrl,
    input  count_t     load_count,
    input  count_t     shift_count,
    output count_t     count
);

    count_t count_reg;
    count_t count_next;

    // the cell at the row end takes the new count, the others take their neighbor's
    always_comb
    begin
        count_next = ctrl.load ? load_count : shift_count;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

### rtl/core/grid_path_count_mod_prime.sv
// a result is registered and shown in the cycle after its cell item is accepted
// throughput: one item per cycle unless the output stalls, set by the single add
//   and conditional prime subtract between the row buffer head and output register
// the row buffer is a chain of cells that shifts once per accepted item
// reset: grid 4 x 3, counters and left count cleared, output empty;
//   the row buffer is not cleared, row 0 never reads it
`default_nettype none

module grid_path_count_mod_prime
    import gpc_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_we,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data,
    gpc_in_if.sink                 cells,
    gpc_out_if.source              counts
);

    // configuration registers
    logic [GRID_WIDTH_W-1:0]  grid_width_reg;
    logic [GRID_HEIGHT_W-1:0] grid_height_reg;

    // grid position and the count of the left neighbor
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    count_t           left_reg;
    count_t           left_next;

    // output register
    logic   out_valid_reg;
    logic   out_valid_next;
    count_t path_count_reg;
    logic   is_final_reg;

    logic             in_fire;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic             at_last_col;
    logic             at_final;
    count_t           above;
    count_t           left;
    logic [COUNT_W:0] sum;
    count_t           cell_val;

    // row buffer: a chain of cells, head at cell 0
    count_t     chain [MAX_WIDTH];
    cell_ctrl_t cell_ctrl [MAX_WIDTH];

    // handshake: a new item goes in while the output register is empty or drains
    assign in_fire     = cells.valid && cells.ready;
    assign cells.ready = !out_valid_reg || counts.ready;

    // effective last column and row, with zero and oversize clamped
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_last = '0;
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = COL_W'(grid_width_reg - GRID_WIDTH_W'(1));
        end

        if (grid_height_reg == '0)
        begin
            h_last = '0;
        end
        else if (32'(grid_height_reg) > HEIGHT_LIMIT)
        begin
            h_last = ROW_W'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_last = ROW_W'(grid_height_reg - GRID_HEIGHT_W'(1));
        end
    end

    assign at_last_col = (col_reg == w_last);
    assign at_final    = at_last_col && (row_reg == h_last);

    // count of the current cell: zero if blocked, one at top-left, else above plus left, one conditional subtract
    always_comb
    begin
        above = (row_reg == '0) ? '0 : chain[0];
        left  = (col_reg == '0) ? '0 : left_reg;
        sum   = {1'b0, above} + {1'b0, left};

        if (cells.blocked)
        begin
            cell_val = '0;
        end
        else if ((row_reg == '0) && (col_reg == '0))
        begin
            // top-left cell seeds the grid
            cell_val = COUNT_W'(1);
        end
        else if (sum >= {1'b0, PRIME})
        begin
            cell_val = COUNT_W'(sum - {1'b0, PRIME});
        end
        else
        begin
            cell_val = COUNT_W'(sum);
        end
    end

    // raster walk; a config write restarts the grid
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;

        if (cfg_we)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = '0;
        end
        else if (in_fire)
        begin
            if (at_final)
            begin
                col_next  = '0;
                row_next  = '0;
                left_next = '0;
            end
            else if (at_last_col)
            begin
                col_next  = '0;
                row_next  = row_reg + ROW_W'(1);
                left_next = '0;
            end
            else
            begin
                col_next  = col_reg + COL_W'(1);
                left_next = cell_val;
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (counts.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_W'(4);
            grid_height_reg <= GRID_HEIGHT_W'(3);
            col_reg         <= '0;
            row_reg         <= '0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_GRID_WIDTH:  grid_width_reg  <= GRID_WIDTH_W'(cfg_data);
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            path_count_reg <= cell_val;
            is_final_reg   <= at_final;
        end
    end

    assign counts.valid      = out_valid_reg;
    assign counts.path_count = path_count_reg;
    assign counts.is_final   = is_final_reg;

    // the new count enters at the row end and reaches the head one row later
    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_cell
        count_t shift_in;

        if (i == MAX_WIDTH - 1)
        begin : g_tail
            assign shift_in = '0;
        end
        else
        begin : g_body
            assign shift_in = chain[i+1];
        end

        assign cell_ctrl[i].shift = in_fire;
        assign cell_ctrl[i].load  = (w_last == COL_W'(i));

        gpc_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .load_count  (cell_val),
            .shift_count (shift_in),
            .count       (chain[i])
        );
    end

    // a shown count is always reduced below the prime
    assert property (@(posedge clk) disable iff (!rst_n)
        counts.valid |-> (counts.path_count < PRIME))
        else $error("path count not reduced");

    // a blocked cell yields a zero count in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cells.blocked) |=> (counts.valid && (counts.path_count == '0)))
        else $error("blocked cell gave nonzero count");

    // after the final cell the walk restarts at the top-left cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && at_final) |=> ((col_reg == '0) && (row_reg == '0)))
        else $error("grid did not restart");

    // the column never runs past the configured row end
    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last)
        else $error("column beyond row end");

endmodule

`default_nettype wire

### verif/grid_path_count_mod_prime_tb.sv
`timescale 1ns / 100ps

module grid_path_count_mod_prime_tb
    import gpc_pkg::*;
;

    // stop sending random cells once this many have gone in
    localparam int RANDOM_ITEMS  = 800;
    // the block shows a result in the cycle after the cell is taken
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        count_t path_count;
        logic   is_final;
    } cell_result_t;

    logic clk;
    logic rst_n;

    logic                     cfg_we;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    gpc_in_if  cells_ch ();
    gpc_out_if counts_ch ();

    grid_path_count_mod_prime dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells_ch),
        .counts    (counts_ch)
    );

    // own copy of the grid settings and the counting state
    logic [GRID_WIDTH_W-1:0]  width_reg;
    logic [GRID_HEIGHT_W-1:0] height_reg;
    count_t                   above_row [MAX_WIDTH];
    count_t                   left_sum;
    int unsigned              cur_col;
    int unsigned              cur_row;

    // counts worked out for cells taken but not yet seen on the output
    cell_result_t pending_counts [$];
    cell_result_t want_count;
    int           error_count;

    // sender burst bookkeeping
    int burst_left;
    int random_sent;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hard stop in case the output never drains
    initial
    begin
        #(10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: rotates a 16-bit ready pattern, replaced by a new one after a random run;
    // the pattern is never all zero, so every stall ends
    initial
    begin
        logic [15:0] ready_pattern;
        int          pattern_left;
        ready_pattern = 16'hFFFF;
        pattern_left  = 0;
        counts_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom) & 16'($urandom);
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
                ready_pattern[0] = 1'b1;
                pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            counts_ch.ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // any write to a grid register starts a fresh grid
    function automatic void restart_grid();
        left_sum = '0;
        cur_col  = 0;
        cur_row  = 0;
    endfunction

    // one cell: blocked gives 0, top-left gives 1, else above + left mod prime;
    // the row buffer entry and left count take the new value
    function automatic void predict_path_count(input logic blk);
        int unsigned  w;
        int unsigned  h;
        int unsigned  col;
        int unsigned  row;
        logic [31:0]  sum;
        cell_result_t res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
        col = (cur_col >= w) ? w - 1 : cur_col;
        row = (cur_row >= h) ? h - 1 : cur_row;
        if (blk)
            sum = 0;
        else if (row == 0 && col == 0)
            sum = 1;
        else
        begin
            sum = ((row == 0) ? 32'd0 : 32'(above_row[col]))
                + ((col == 0) ? 32'd0 : 32'(left_sum));
            if (sum >= 32'(PRIME))
                sum = sum - 32'(PRIME);
        end
        above_row[col] = count_t'(sum);
        left_sum       = count_t'(sum);
        res.path_count = count_t'(sum);
        res.is_final   = (col == w - 1) && (row == h - 1);
        // advance raster position: wrap on the last column, restart after the last cell
        if (res.is_final)
            restart_grid();
        else if (col == w - 1)
        begin
            cur_col  = 0;
            cur_row  = row + 1;
            left_sum = '0;
        end
        else
        begin
            cur_col = col + 1;
            cur_row = row;
        end
        pending_counts.push_back(res);
    endfunction

    // present one cell; bursts of random length with random gaps between them
    task automatic send_cell(input logic blk);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                cells_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cells_ch.valid   <= 1'b1;
        cells_ch.blocked <= blk;
        do
            @(posedge clk);
        while (!cells_ch.ready);
        predict_path_count(blk);
    endtask

    // send a run of cells, each blocked with the given chance in percent
    task automatic send_cells(input int num_cells, input int blocked_pct);
        for (int i = 0; i < num_cells; i++)
            send_cell($urandom_range(0, 99) < blocked_pct);
    endtask

    // register writes only once the output has drained
    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cells_ch.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GRID_WIDTH)
            width_reg = data[GRID_WIDTH_W-1:0];
        else
            height_reg = data;
        restart_grid();
        @(posedge clk);
    endtask

    // checker: every output item against the oldest waiting count
    always @(posedge clk)
    begin
        if (rst_n && counts_ch.valid && counts_ch.ready)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("unexpected item: path_count %0d is_final %0b",
                       counts_ch.path_count, counts_ch.is_final);
                error_count++;
            end
            else
            begin
                want_count = pending_counts.pop_front();
                if (counts_ch.path_count !== want_count.path_count)
                begin
                    $error("path_count mismatch: expected %0d, actual %0d",
                           want_count.path_count, counts_ch.path_count);
                    error_count++;
                end
                if (counts_ch.is_final !== want_count.is_final)
                begin
                    $error("is_final mismatch: expected %0b, actual %0b",
                           want_count.is_final, counts_ch.is_final);
                    error_count++;
                end
            end
        end
    end

    // reset grid 4 x 3 fully open, then with the top-left cell and one inner cell blocked
    task automatic test_reset_grid();
        send_cells(12, 0);
        send_cell(1'b1);
        send_cells(4, 0);
        send_cell(1'b1);
        send_cells(6, 0);
    endtask

    // width 0 and height 0 both act as 1: a single-cell grid, open then blocked
    task automatic test_zero_sizes();
        write_cfg(CFG_GRID_WIDTH, '0);
        write_cfg(CFG_GRID_HEIGHT, '0);
        send_cell(1'b0);
        send_cell(1'b1);
    endtask

    // a write part way through a grid starts over at the top-left cell
    task automatic test_restart_on_write();
        write_cfg(CFG_GRID_WIDTH, 13'd3);
        write_cfg(CFG_GRID_HEIGHT, 13'd2);
        send_cell(1'b0);
        send_cell(1'b0);
        write_cfg(CFG_GRID_WIDTH, 13'd3);
        send_cell(1'b1);
        send_cell(1'b0);
        send_cell(1'b0);
        send_cell(1'b0);
        send_cell(1'b1);
        send_cell(1'b0);
    endtask

    // widest grid, then a width above the row buffer that saturates, upper data bits set
    task automatic test_width_extremes();
        write_cfg(CFG_GRID_WIDTH, 13'd128);
        write_cfg(CFG_GRID_HEIGHT, 13'd2);
        send_cells(256, 10);
        write_cfg(CFG_GRID_WIDTH, 13'h1FFF);
        write_cfg(CFG_GRID_HEIGHT, 13'd2);
        send_cells(256, 5);
    endtask

    // tallest grid one column wide, then a height past the limit that saturates;
    // both are cut short by the next register write
    task automatic test_height_extremes();
        write_cfg(CFG_GRID_WIDTH, 13'd1);
        write_cfg(CFG_GRID_HEIGHT, 13'd4096);
        send_cells(150, 1);
        write_cfg(CFG_GRID_HEIGHT, 13'h1FFF);
        send_cells(150, 0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_GRID_WIDTH;
        cfg_data       = '0;
        cells_ch.valid   = 1'b0;
        cells_ch.blocked = 1'b0;
        error_count    = 0;
        burst_left     = 0;
        random_sent    = 0;
        width_reg      = GRID_WIDTH_W'(4);
        height_reg     = GRID_HEIGHT_W'(3);
        restart_grid();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_grid();
        test_zero_sizes();
        test_restart_on_write();
        test_width_extremes();
        test_height_extremes();
        test_random_grids();

        // drain, then keep clocking so the block can show anything stray
        cells_ch.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // random grids: mostly small, some wide, some deep enough to wrap the prime;
    // a few are cut short and some run back to back on the same settings
    task automatic test_random_grids();
        int w;
        int h;
        int num_cells;
        int blocked_pct;
        int need_cfg;
        logic [GRID_WIDTH_W-1:0] width_code;
        need_cfg = 1;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (need_cfg || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                    begin
                        // wide and shallow
                        w = $urandom_range(64, 128);
                        h = $urandom_range(1, 4);
                    end
                    3, 4:
                    begin
                        // deep, near square, counts can pass the prime
                        w = $urandom_range(17, 22);
                        h = $urandom_range(17, 22);
                    end
                    5, 6, 7:
                    begin
                        // tall and thin
                        w = $urandom_range(1, 4);
                        h = $urandom_range(20, 200);
                    end
                    default:
                    begin
                        w = $urandom_range(1, 10);
                        h = $urandom_range(1, 10);
                    end
                endcase
                // width codes 0 and above 128 land on 1 and 128
                width_code = GRID_WIDTH_W'(w);
                if (w == 1 && $urandom_range(0, 2) == 0)
                    width_code = '0;
                else if (w == 128 && $urandom_range(0, 1) == 0)
                    width_code = GRID_WIDTH_W'($urandom_range(129, 255));
                if ($urandom_range(0, 1) == 0)
                begin
                    write_cfg(CFG_GRID_WIDTH, {5'($urandom), width_code});
                    write_cfg(CFG_GRID_HEIGHT, (h == 1 && $urandom_range(0, 1) == 0)
                                               ? 13'd0 : 13'(h));
                end
                else
                begin
                    write_cfg(CFG_GRID_HEIGHT, (h == 1 && $urandom_range(0, 1) == 0)
                                               ? 13'd0 : 13'(h));
                    write_cfg(CFG_GRID_WIDTH, {5'($urandom), width_code});
                end
            end
            need_cfg = 0;
            num_cells = w * h;
            // now and then stop part way and restart with a register write
            if ($urandom_range(0, 9) == 0)
            begin
                num_cells = $urandom_range(1, num_cells);
                need_cfg = 1;
            end
            case ($urandom_range(0, 3))
                0:       blocked_pct = 0;
                1:       blocked_pct = 5;
                2:       blocked_pct = 20;
                default: blocked_pct = 50;
            endcase
            send_cells(num_cells, blocked_pct);
            random_sent += num_cells;
        end
    endtask

endmodule
